[design/chash_pkg.sv]
// Shared constants, codes and helper functions for the chained hash table.
// Used by chained_hash_table_top and chash_ram users; depends on nothing.
package chash_pkg;

  localparam int NUM_BUCKETS = 5;
  localparam int CHAIN_DEPTH = 8;
  localparam int TOTAL_SLOTS = NUM_BUCKETS * CHAIN_DEPTH;

  localparam int KEY_W    = 31;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int BKT_W    = 3;
  localparam int COUNT_W  = 4;

  localparam int SLOT_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int IDX_W  = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int REM_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  // The key is reduced one nibble per cycle, most significant nibble first.
  localparam int DIGIT_W   = 4;
  localparam int MOD_STEPS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MOD_W     = MOD_STEPS * DIGIT_W;
  localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int V_W       = REM_W + DIGIT_W;
  localparam int MAX_Q     = (1 << DIGIT_W) - 1;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One step of the remainder recurrence: (rem * 16 + digit) mod NUM_BUCKETS.
  // The partial value is below 16 * NUM_BUCKETS, so the quotient digit is
  // found by comparing against every constant multiple in parallel.
  function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0]   rem,
                                                input logic [DIGIT_W-1:0] digit);
    logic [V_W-1:0] v;
    logic [V_W-1:0] sub;
    v   = {rem, digit};
    sub = '0;
    for (int k = 1; k <= MAX_Q; k++) begin
      if (v >= V_W'(k * NUM_BUCKETS)) begin
        sub = V_W'(k * NUM_BUCKETS);
      end
    end
    return REM_W'(v - sub);
  endfunction

endpackage

[design/chash_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the slot keys of the chained hash table.
module chash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/chained_hash_table_top.sv]
// Top level of the chained hash table: request sequencer, slot valid bits
// and result register. Depends on chash_pkg and chash_ram.
//
// Requests arrive on the in_ channel: in_tuser carries the request type
// (insert, delete all copies, find) and in_tdata the 31-bit key. Each
// request gives exactly one result on the out_ channel: out_tuser is the
// status, out_tdata holds the bucket and the match count.
// The block works on one request at a time and drops in_tready meanwhile.
// A request first reduces its key modulo the bucket count, one nibble per
// cycle, then forms the bucket base address. An insert then checks slot
// valid bits one per cycle, lowest slot first. A delete or find reads the
// key RAM one slot per cycle and compares each slot behind its read, as the
// read data is registered. The S_FIN state then loads the result, and the
// next request is taken in the cycle after the result is loaded. The result
// sits in an output register: the block takes a new request while an older
// result waits, and holds a newly finished result only while that register
// is still full and not taken.
// Reset (rst_n low, synchronous) clears all slot valid bits at once, so the
// table is empty; the key RAM needs no clearing.
module chained_hash_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] key
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] bucket, [6:3] match_count
  output logic [1:0]  out_tuser   // [1:0] status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_BASE,
    S_INS,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [chash_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [chash_pkg::REQ_W-1:0]    req_r, req_nxt;
  logic [chash_pkg::MOD_W-1:0]    shift_r, shift_nxt;
  logic [chash_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [chash_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [chash_pkg::SLOT_W-1:0]   base_r, base_nxt;
  logic [chash_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic                           issue_done_r, issue_done_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic                           cmp_last_r, cmp_last_nxt;
  logic [chash_pkg::SLOT_W-1:0]   cmp_slot_r, cmp_slot_nxt;
  logic [chash_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [chash_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [chash_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [chash_pkg::BKT_W-1:0]    out_bucket_r, out_bucket_nxt;
  logic [chash_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic [chash_pkg::TOTAL_SLOTS-1:0] valid_r, valid_nxt;

  logic [chash_pkg::SLOT_W-1:0] slot_addr;
  logic [chash_pkg::SLOT_W-1:0] chk_slot;
  logic                         chk_valid;
  logic                         ram_we;
  logic [chash_pkg::KEY_W-1:0]  ram_rdata;
  logic                         hit;
  logic [chash_pkg::COUNT_W-1:0] count_inc;
  logic                         in_fire;

  chash_ram #(
    .WIDTH (chash_pkg::KEY_W),
    .DEPTH (chash_pkg::TOTAL_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_addr),
    .wdata (key_r),
    .raddr (slot_addr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_count_r, out_bucket_r};

  // Slot of the bucket currently addressed by the index counter.
  assign slot_addr = chash_pkg::SLOT_W'(base_r + chash_pkg::SLOT_W'(idx_r));
  assign chk_slot  = (state_r == S_INS) ? slot_addr : cmp_slot_r;
  assign chk_valid = valid_r[chk_slot];
  assign ram_we    = (state_r == S_INS) && !chk_valid;
  assign hit       = cmp_vld_r && chk_valid && (ram_rdata == key_r);
  assign count_inc = (count_r == chash_pkg::COUNT_MAX) ? count_r
                                                       : count_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    req_nxt        = req_r;
    shift_nxt      = shift_r;
    step_nxt       = step_r;
    rem_nxt        = rem_r;
    base_nxt       = base_r;
    idx_nxt        = idx_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_last_nxt   = 1'b0;
    cmp_slot_nxt   = cmp_slot_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_bucket_nxt = out_bucket_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt   = in_tdata[chash_pkg::KEY_W-1:0];
          req_nxt   = in_tuser;
          shift_nxt = chash_pkg::MOD_W'(in_tdata[chash_pkg::KEY_W-1:0]);
          step_nxt  = '0;
          rem_nxt   = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        rem_nxt   = chash_pkg::mod_step(rem_r,
                      shift_r[chash_pkg::MOD_W-1 -: chash_pkg::DIGIT_W]);
        shift_nxt = shift_r << chash_pkg::DIGIT_W;
        step_nxt  = step_r + 1'b1;
        if (step_r == chash_pkg::STEP_W'(chash_pkg::MOD_STEPS - 1)) begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        base_nxt       = chash_pkg::SLOT_W'(32'(rem_r) * chash_pkg::CHAIN_DEPTH);
        idx_nxt        = '0;
        issue_done_nxt = 1'b0;
        count_nxt      = '0;
        state_nxt      = (req_r == chash_pkg::REQ_INSERT) ? S_INS : S_SCAN;
      end
      S_INS: begin
        if (!chk_valid) begin
          valid_nxt[slot_addr] = 1'b1;
          status_nxt = chash_pkg::ST_DONE;
          count_nxt  = chash_pkg::COUNT_W'(1);
          state_nxt  = S_FIN;
        end else if (idx_r == chash_pkg::IDX_W'(chash_pkg::CHAIN_DEPTH - 1)) begin
          status_nxt = chash_pkg::ST_FULL;
          count_nxt  = '0;
          state_nxt  = S_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SCAN: begin
        // Read of one slot is issued while the previous slot is compared.
        if (!issue_done_r) begin
          cmp_vld_nxt  = 1'b1;
          cmp_slot_nxt = slot_addr;
          if (idx_r == chash_pkg::IDX_W'(chash_pkg::CHAIN_DEPTH - 1)) begin
            cmp_last_nxt   = 1'b1;
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (hit) begin
          count_nxt = count_inc;
          if (req_r == chash_pkg::REQ_DELETE) begin
            valid_nxt[cmp_slot_r] = 1'b0;
          end
        end
        if (cmp_vld_r && cmp_last_r) begin
          status_nxt = ((hit ? count_inc : count_r) != '0) ? chash_pkg::ST_DONE
                                                          : chash_pkg::ST_NOT_FOUND;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_bucket_nxt = chash_pkg::BKT_W'(rem_r);
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      cmp_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      cmp_last_r  <= cmp_last_nxt;
    end
    key_r        <= key_nxt;
    req_r        <= req_nxt;
    shift_r      <= shift_nxt;
    step_r       <= step_nxt;
    rem_r        <= rem_nxt;
    base_r       <= base_nxt;
    idx_r        <= idx_nxt;
    issue_done_r <= issue_done_nxt;
    cmp_slot_r   <= cmp_slot_nxt;
    count_r      <= count_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule
